/* hw/rtl/kam_pkg.sv */
// Shared types and constants of the keyed alphabet mutator.
// Used by kam_front, kam_queue, kam_back and keyed_alphabet_mutator_top; depends on nothing.
`default_nettype none

package kam_pkg;

   localparam int ALPHABET_LETTERS_DEF = 26;

   localparam int LEN_W       = 5;
   localparam int SYM_W       = 5;
   localparam int DRAW_W      = 16;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] REG_RESIZE_THR = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SWAP_THR   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_KW     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_KW     = 4'd3;

   localparam logic [DRAW_W-1:0] RESIZE_THR_RST = 16'd2621;
   localparam logic [DRAW_W-1:0] SWAP_THR_RST   = 16'd34079;
   localparam logic [LEN_W-1:0]  MIN_KW_RST     = 5'd3;
   localparam logic [LEN_W-1:0]  MAX_KW_RST     = 5'd13;
   localparam logic [LEN_W-1:0]  KEYWORD_RST    = 5'd3;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_SWAP,
      OP_SWAP_REBUILD,
      OP_REBUILD
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [LEN_W-1:0]  addr_a;
      logic [LEN_W-1:0]  addr_b;
      logic [SYM_W-1:0]  symbol;
      logic [LEN_W-1:0]  len;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWAP_RD,
      ST_SWAP_WA,
      ST_SWAP_WB,
      ST_SCAN,
      ST_FILL,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/kam_front.sv */
// Front end: configuration registers, item intake, move classification and index scaling.
// Tracks the keyword length itself and hands kam_pkg::cmd_type commands to the queue.
`default_nettype none

module kam_front #(
   parameter int ALPHABET_LETTERS = kam_pkg::ALPHABET_LETTERS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [kam_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [kam_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire                              action,
   input  wire  [kam_pkg::LEN_W-1:0]        slot,
   input  wire  [kam_pkg::SYM_W-1:0]        symbol,
   input  wire  [kam_pkg::LEN_W-1:0]        prefix_length,
   input  wire  [kam_pkg::DRAW_W-1:0]       class_draw,
   input  wire                              direction_bit,
   input  wire  [kam_pkg::DRAW_W-1:0]       first_draw,
   input  wire  [kam_pkg::DRAW_W-1:0]       second_draw,
   input  wire                              q_full,
   output logic                             push_valid,
   output kam_pkg::cmd_type                 push_cmd
);

   localparam int PW = kam_pkg::DRAW_W + kam_pkg::LEN_W;
   localparam logic [kam_pkg::LEN_W:0] N_LEN = (kam_pkg::LEN_W + 1)'(ALPHABET_LETTERS);
   localparam logic [kam_pkg::LEN_W:0] K_MAX = (kam_pkg::LEN_W + 1)'(ALPHABET_LETTERS - 1);

   logic [kam_pkg::DRAW_W-1:0] resize_thr_ff;
   logic [kam_pkg::DRAW_W-1:0] swap_thr_ff;
   logic [kam_pkg::LEN_W-1:0]  min_kw_ff;
   logic [kam_pkg::LEN_W-1:0]  max_kw_ff;
   logic [kam_pkg::LEN_W-1:0]  keyword_len_ff;
   logic [kam_pkg::LEN_W-1:0]  keyword_len_in;

   logic                       accept;
   logic [PW-1:0]              prod_a;
   logic [PW-1:0]              prod_b;
   logic [PW-1:0]              prod_c;
   logic [kam_pkg::LEN_W-1:0]  tail_n;
   logic [kam_pkg::LEN_W-1:0]  idx_i;
   logic [kam_pkg::LEN_W-1:0]  idx_j;
   logic [kam_pkg::LEN_W-1:0]  idx_k;
   logic [kam_pkg::LEN_W:0]    k_step;
   logic [kam_pkg::LEN_W-1:0]  k_resized;

   function automatic logic [kam_pkg::LEN_W-1:0] clamp_len(input logic [kam_pkg::LEN_W:0] v);
      logic [kam_pkg::LEN_W:0] r;
      if (v == '0) begin
         r = (kam_pkg::LEN_W + 1)'(1);
      end else if (v > K_MAX) begin
         r = K_MAX;
      end else begin
         r = v;
      end
      return r[kam_pkg::LEN_W-1:0];
   endfunction

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         resize_thr_ff <= kam_pkg::RESIZE_THR_RST;
         swap_thr_ff   <= kam_pkg::SWAP_THR_RST;
         min_kw_ff     <= kam_pkg::MIN_KW_RST;
         max_kw_ff     <= kam_pkg::MAX_KW_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            kam_pkg::REG_RESIZE_THR: resize_thr_ff <= csr_data;
            kam_pkg::REG_SWAP_THR:   swap_thr_ff   <= csr_data;
            kam_pkg::REG_MIN_KW:     min_kw_ff     <= csr_data[kam_pkg::LEN_W-1:0];
            kam_pkg::REG_MAX_KW:     max_kw_ff     <= csr_data[kam_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keyword_len_ff <= kam_pkg::KEYWORD_RST;
      end else begin
         keyword_len_ff <= keyword_len_in;
      end
   end

   // scale draws: floor(d * range / 65536)
   always_comb begin
      tail_n = kam_pkg::LEN_W'(N_LEN - {1'b0, keyword_len_ff});
      prod_a = PW'(first_draw) * PW'(keyword_len_ff);
      prod_b = PW'(second_draw) * PW'(tail_n);
      prod_c = PW'(second_draw) * PW'(keyword_len_ff);
      idx_i  = prod_a[PW-1:kam_pkg::DRAW_W];
      idx_j  = keyword_len_ff + prod_b[PW-1:kam_pkg::DRAW_W];
      idx_k  = prod_c[PW-1:kam_pkg::DRAW_W];
   end

   always_comb begin
      if (keyword_len_ff <= min_kw_ff) begin
         k_step = {1'b0, keyword_len_ff} + 1'b1;
      end else if (keyword_len_ff >= max_kw_ff) begin
         k_step = {1'b0, keyword_len_ff} - 1'b1;
      end else if (direction_bit) begin
         k_step = {1'b0, keyword_len_ff} + 1'b1;
      end else begin
         k_step = {1'b0, keyword_len_ff} - 1'b1;
      end
      k_resized = clamp_len(k_step);
   end

   always_comb begin
      keyword_len_in  = keyword_len_ff;
      push_valid      = 1'b0;
      push_cmd.op     = kam_pkg::OP_LOAD;
      push_cmd.addr_a = slot;
      push_cmd.addr_b = idx_j;
      push_cmd.symbol = symbol;
      push_cmd.len    = keyword_len_ff;
      if (accept) begin
         if (!action) begin
            // drop loads aimed past the alphabet; the length still takes effect
            keyword_len_in = clamp_len({1'b0, prefix_length});
            push_valid     = ({1'b0, slot} < N_LEN);
         end else begin
            push_valid = 1'b1;
            if (class_draw < resize_thr_ff) begin
               push_cmd.op    = kam_pkg::OP_REBUILD;
               push_cmd.len   = k_resized;
               keyword_len_in = k_resized;
            end else if (class_draw < swap_thr_ff) begin
               push_cmd.op     = kam_pkg::OP_SWAP_REBUILD;
               push_cmd.addr_a = idx_i;
               push_cmd.addr_b = idx_j;
            end else begin
               // keyword swap scales the second draw by k, not by the tail size
               push_cmd.op     = kam_pkg::OP_SWAP;
               push_cmd.addr_a = idx_i;
               push_cmd.addr_b = idx_k;
            end
         end
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/kam_queue.sv */
// Short command queue between the front end and the back end.
// Holds kam_pkg::cmd_type entries; depth is kam_pkg::QUEUE_DEPTH (a power of two).
`default_nettype none

module kam_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push_valid,
   input  kam_pkg::cmd_type  push_cmd,
   output logic              full,
   input  wire               pop,
   output kam_pkg::cmd_type  head_cmd,
   output logic              empty
);

   localparam int PTR_W = (kam_pkg::QUEUE_DEPTH > 1) ? $clog2(kam_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(kam_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(kam_pkg::QUEUE_DEPTH);

   kam_pkg::cmd_type   slots_ff [kam_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign head_cmd = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/kam_back.sv */
// Back end: alphabet memory, swap sequencer, tail rebuild and entry emission.
// Takes commands from kam_queue; types and state codes from kam_pkg.
`default_nettype none

module kam_back #(
   parameter int ALPHABET_LETTERS = kam_pkg::ALPHABET_LETTERS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          q_empty,
   input  kam_pkg::cmd_type             q_cmd,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [kam_pkg::LEN_W-1:0]    out_slot,
   output logic [kam_pkg::SYM_W-1:0]    out_symbol,
   output logic [kam_pkg::LEN_W-1:0]    out_prefix_length,
   output logic                         last
);

   localparam int IW = $clog2(ALPHABET_LETTERS);
   localparam int CW = $clog2(ALPHABET_LETTERS + 1);
   localparam logic [CW-1:0] N_CW = CW'(ALPHABET_LETTERS);
   localparam logic [IW-1:0] LAST_IDX = IW'(ALPHABET_LETTERS - 1);
   localparam logic [kam_pkg::SYM_W:0] N_SYM = (kam_pkg::SYM_W + 1)'(ALPHABET_LETTERS);

   logic [kam_pkg::SYM_W-1:0] mem [ALPHABET_LETTERS];

   kam_pkg::state_type        state_ff, state_in;
   kam_pkg::cmd_type          cmd_ff, cmd_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [CW-1:0]             m_ff, m_in;
   logic [ALPHABET_LETTERS-1:0] seen_ff, seen_in;
   logic                      scan_vld_ff, scan_vld_in;
   logic                      pend_ff, pend_in;
   logic [IW-1:0]             pend_slot_ff, pend_slot_in;
   logic [kam_pkg::SYM_W-1:0] rd_a_ff, rd_b_ff;

   logic                      wr_en;
   logic [IW-1:0]             wr_addr;
   logic [kam_pkg::SYM_W-1:0] wr_data;
   logic                      rd_a_en, rd_b_en;
   logic [IW-1:0]             rd_a_addr, rd_b_addr;
   logic                      issue;
   logic                      load_out;
   logic [CW-1:0]             len_cw;

   logic                      out_valid_ff;
   logic [kam_pkg::LEN_W-1:0] out_slot_ff;
   logic [kam_pkg::SYM_W-1:0] out_symbol_ff;
   logic [kam_pkg::LEN_W-1:0] out_len_ff;
   logic                      out_last_ff;

   assign len_cw   = CW'(cmd_ff.len);
   assign load_out = pend_ff && (!out_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= mem[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= mem[rd_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= kam_pkg::ST_IDLE;
         scan_vld_ff <= 1'b0;
         pend_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_vld_ff <= scan_vld_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      cnt_ff       <= cnt_in;
      m_ff         <= m_in;
      seen_ff      <= seen_in;
      pend_slot_ff <= pend_slot_in;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      cnt_in      = cnt_ff;
      m_in        = m_ff;
      seen_in     = seen_ff;
      scan_vld_in = 1'b0;
      pop         = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      rd_a_en     = 1'b0;
      rd_a_addr   = '0;
      rd_b_en     = 1'b0;
      rd_b_addr   = '0;
      issue       = 1'b0;
      unique case (state_ff)
         kam_pkg::ST_IDLE: begin
            if (!q_empty) begin
               pop    = 1'b1;
               cmd_in = q_cmd;
               unique case (q_cmd.op)
                  kam_pkg::OP_LOAD: begin
                     wr_en   = 1'b1;
                     wr_addr = q_cmd.addr_a[IW-1:0];
                     wr_data = q_cmd.symbol;
                  end
                  kam_pkg::OP_REBUILD: begin
                     state_in = kam_pkg::ST_SCAN;
                     cnt_in   = '0;
                     seen_in  = '0;
                  end
                  default: begin
                     state_in = kam_pkg::ST_SWAP_RD;
                  end
               endcase
            end
         end
         kam_pkg::ST_SWAP_RD: begin
            rd_a_en   = 1'b1;
            rd_a_addr = cmd_ff.addr_a[IW-1:0];
            rd_b_en   = 1'b1;
            rd_b_addr = cmd_ff.addr_b[IW-1:0];
            state_in  = kam_pkg::ST_SWAP_WA;
         end
         kam_pkg::ST_SWAP_WA: begin
            wr_en    = 1'b1;
            wr_addr  = cmd_ff.addr_a[IW-1:0];
            wr_data  = rd_b_ff;
            state_in = kam_pkg::ST_SWAP_WB;
         end
         kam_pkg::ST_SWAP_WB: begin
            wr_en   = 1'b1;
            wr_addr = cmd_ff.addr_b[IW-1:0];
            wr_data = rd_a_ff;
            cnt_in  = '0;
            if (cmd_ff.op == kam_pkg::OP_SWAP_REBUILD) begin
               state_in = kam_pkg::ST_SCAN;
               seen_in  = '0;
            end else begin
               state_in = kam_pkg::ST_EMIT;
            end
         end
         kam_pkg::ST_SCAN: begin
            // mark the letters held by the keyword prefix
            if (scan_vld_ff && ({1'b0, rd_a_ff} < N_SYM)) begin
               seen_in[rd_a_ff[IW-1:0]] = 1'b1;
            end
            if (cnt_ff < len_cw) begin
               rd_a_en     = 1'b1;
               rd_a_addr   = cnt_ff[IW-1:0];
               cnt_in      = cnt_ff + 1'b1;
               scan_vld_in = 1'b1;
            end else begin
               state_in = kam_pkg::ST_FILL;
               cnt_in   = '0;
               m_in     = len_cw;
            end
         end
         kam_pkg::ST_FILL: begin
            // write unmarked letters in ascending order behind the prefix
            if (cnt_ff == N_CW || m_ff == N_CW) begin
               state_in = kam_pkg::ST_EMIT;
               cnt_in   = '0;
            end else begin
               if (!seen_ff[cnt_ff[IW-1:0]]) begin
                  wr_en   = 1'b1;
                  wr_addr = m_ff[IW-1:0];
                  wr_data = kam_pkg::SYM_W'(cnt_ff);
                  m_in    = m_ff + 1'b1;
               end
               cnt_in = cnt_ff + 1'b1;
            end
         end
         kam_pkg::ST_EMIT: begin
            issue = (cnt_ff != N_CW) && (!pend_ff || load_out);
            if (issue) begin
               rd_a_en   = 1'b1;
               rd_a_addr = cnt_ff[IW-1:0];
               cnt_in    = cnt_ff + 1'b1;
            end
            if (cnt_ff == N_CW && !pend_ff) begin
               state_in = kam_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kam_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pend_slot_in = pend_slot_ff;
      if (issue) begin
         pend_in      = 1'b1;
         pend_slot_in = cnt_ff[IW-1:0];
      end else if (load_out) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
   end

   // output register: hold until taken, refill from the read pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_slot_ff   <= kam_pkg::LEN_W'(pend_slot_ff);
         out_symbol_ff <= rd_a_ff;
         out_len_ff    <= cmd_ff.len;
         out_last_ff   <= (pend_slot_ff == LAST_IDX);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign out_slot          = out_slot_ff;
   assign out_symbol        = out_symbol_ff;
   assign out_prefix_length = out_len_ff;
   assign last              = out_last_ff;

endmodule

`default_nettype wire

/* hw/rtl/keyed_alphabet_mutator_top.sv */
// Top level of the keyed alphabet mutator: stream ports, front end, command queue, back end.
// Depends on kam_pkg, kam_front, kam_queue and kam_back.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  req_tdata (64 bit), req_tuser (action)
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata (16 bit), rsp_tlast
//   csr      in         csr_valid/csr_ready    csr_index (4 bit), csr_data (16 bit)
//
// The front takes one beat per cycle while the two-entry queue has room. In the back a
// load is a single write, a keyword swap swaps and emits, a resize rebuilds the tail and
// emits, and a keyword-tail swap swaps, rebuilds and emits: the single-write alphabet
// memory walks the prefix, the letter scan and the emission one entry a cycle (the
// emission while rsp is not stalled). Reset is synchronous; the alphabet itself is not
// cleared. A stalled rsp holds the output register and the read pipe.
`default_nettype none

module keyed_alphabet_mutator_top #(
   parameter int ALPHABET_LETTERS = kam_pkg::ALPHABET_LETTERS_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // slot[4:0] symbol[9:5] prefix_length[14:10] class_draw[30:15] direction_bit[31]
   // first_draw[47:32] second_draw[63:48]
   input  wire  [63:0]                     req_tdata,
   // action[0]
   input  wire  [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // out_slot[4:0] out_symbol[9:5] out_prefix_length[14:10], zero[15]
   output logic [15:0]                     rsp_tdata,
   output logic                            rsp_tlast,
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [kam_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [kam_pkg::CSR_DATA_W-1:0]  csr_data
);

   kam_pkg::cmd_type          push_cmd;
   kam_pkg::cmd_type          head_cmd;
   logic                      push_valid;
   logic                      q_full;
   logic                      q_empty;
   logic                      pop;
   logic [kam_pkg::LEN_W-1:0] out_slot;
   logic [kam_pkg::SYM_W-1:0] out_symbol;
   logic [kam_pkg::LEN_W-1:0] out_prefix_length;

   kam_front #(
      .ALPHABET_LETTERS (ALPHABET_LETTERS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .action        (req_tuser[0]),
      .slot          (req_tdata[4:0]),
      .symbol        (req_tdata[9:5]),
      .prefix_length (req_tdata[14:10]),
      .class_draw    (req_tdata[30:15]),
      .direction_bit (req_tdata[31]),
      .first_draw    (req_tdata[47:32]),
      .second_draw   (req_tdata[63:48]),
      .q_full        (q_full),
      .push_valid    (push_valid),
      .push_cmd      (push_cmd)
   );

   kam_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_cmd   (head_cmd),
      .empty      (q_empty)
   );

   kam_back #(
      .ALPHABET_LETTERS (ALPHABET_LETTERS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_cmd             (head_cmd),
      .pop               (pop),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .out_slot          (out_slot),
      .out_symbol        (out_symbol),
      .out_prefix_length (out_prefix_length),
      .last              (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, out_prefix_length, out_symbol, out_slot};

endmodule

`default_nettype wire
